FILE: sv/psat_pkg.sv
// shared constants and types for the polygon overlap test
`timescale 1ns / 1ps
package psat_pkg;

  localparam int MAX_VERTS  = 16;
  localparam int COORD_BITS = 16;

  typedef struct packed {
    logic valid;
    logic poly;
    logic first;
  } tag_t;

endpackage

FILE: sv/polygon_sat_overlap_test_unit.sv
// top level: separating axis overlap test of two convex polygons
//
//  channel  dir  tdata                      tuser        tlast
//  s_axis   in   vert_x, vert_y             polygon_id   last_vertex
//  m_axis   out  colliding                  too_many     -
//
// loading accepts one vertex per cycle. per edge axis, the test registers
// the edge normal, scans polygon a then polygon b through one shared
// projection pipeline fed by the rotating vertex chains, drains it and
// checks the intervals; the result then goes into the output register.
// input stalls during the test; a finished word waits in the output
// register. rst is synchronous and clears counts and control.
`timescale 1ns / 1ps
module polygon_sat_overlap_test_unit #(
  parameter int MAX_VERTS  = psat_pkg::MAX_VERTS,
  parameter int COORD_BITS = psat_pkg::COORD_BITS,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int CNT_W = $clog2(MAX_VERTS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,  // vert_x, vert_y, zero fill
  input  logic            s_axis_tuser,  // polygon_id
  input  logic            s_axis_tlast,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // colliding, zero fill
  output logic            m_axis_tuser   // too_many_vertices
);

  localparam int CW = COORD_BITS;
  localparam int DW = 2 * CW + 2;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_EDGE  = 3'd1;
  localparam logic [2:0] S_SCANA = 3'd2;
  localparam logic [2:0] S_SCANB = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]       state;
  logic             poly;
  logic [CNT_W-1:0] axis_cnt, scan_cnt;
  logic             drain;
  logic             ovf, res_hit, res_ovf;
  logic signed [CW:0] nx, ny;

  logic accept, load_a, load_b, clr, rot_a, rot_b;
  logic [CW-1:0] vx, vy;
  logic [CNT_W-1:0] count_a, count_b, n_p;
  logic full_a, full_b;
  logic [CW-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
  logic signed [CW:0] ex, ey;
  logic signed [DW-1:0] a_lo, a_hi, b_lo, b_hi;
  psat_pkg::tag_t tag;
  logic sep, out_free;

  assign s_axis_tready = (state == S_LOAD);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign vx = s_axis_tdata[CW-1:0];
  assign vy = s_axis_tdata[2*CW-1:CW];
  assign load_a = accept && !s_axis_tuser;
  assign load_b = accept && s_axis_tuser;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign clr = (state == S_RES) && out_free;
  assign rot_a = (state == S_SCANA) || ((state == S_NEXT) && !poly);
  assign rot_b = (state == S_SCANB) || ((state == S_NEXT) && poly);

  psat_chain #(.N(MAX_VERTS), .CW(CW)) u_chain_a (
    .clk(clk), .rst(rst), .load(load_a), .clr(clr), .rot(rot_a),
    .in_x(vx), .in_y(vy), .count(count_a), .full(full_a),
    .h0_x(a0x), .h0_y(a0y), .h1_x(a1x), .h1_y(a1y)
  );

  psat_chain #(.N(MAX_VERTS), .CW(CW)) u_chain_b (
    .clk(clk), .rst(rst), .load(load_b), .clr(clr), .rot(rot_b),
    .in_x(vx), .in_y(vy), .count(count_b), .full(full_b),
    .h0_x(b0x), .h0_y(b0y), .h1_x(b1x), .h1_y(b1y)
  );

  assign n_p = poly ? count_b : count_a;
  assign ex = poly ? ((CW+1)'($signed(b1x)) - (CW+1)'($signed(b0x)))
                   : ((CW+1)'($signed(a1x)) - (CW+1)'($signed(a0x)));
  assign ey = poly ? ((CW+1)'($signed(b1y)) - (CW+1)'($signed(b0y)))
                   : ((CW+1)'($signed(a1y)) - (CW+1)'($signed(a0y)));

  always_comb begin
    tag.valid = (state == S_SCANA) || (state == S_SCANB);
    tag.poly  = (state == S_SCANB);
    tag.first = (scan_cnt == '0);
  end

  psat_proj #(.CW(CW)) u_proj (
    .clk(clk), .rst(rst), .tag(tag), .nx(nx), .ny(ny),
    .vx(tag.poly ? $signed(b0x) : $signed(a0x)),
    .vy(tag.poly ? $signed(b0y) : $signed(a0y)),
    .a_lo(a_lo), .a_hi(a_hi), .b_lo(b_lo), .b_hi(b_hi)
  );

  assign sep = !((a_lo <= b_hi) && (a_hi >= b_lo));

  always_ff @(posedge clk) begin
    if (state == S_EDGE) begin
      nx <= -ey;
      ny <= ex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      poly          <= 1'b0;
      axis_cnt      <= '0;
      scan_cnt      <= '0;
      drain         <= 1'b0;
    end else begin
      if (m_axis_tready && !clr) m_axis_tvalid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            if ((load_a && full_a) || (load_b && full_b)) ovf <= 1'b1;
            if (load_b && s_axis_tlast) begin
              res_ovf <= ovf || full_b;
              res_hit <= 1'b0;
              poly     <= 1'b0;
              axis_cnt <= '0;
              if (ovf || full_b || count_a == '0) state <= S_RES;
              else state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          scan_cnt <= '0;
          state    <= S_SCANA;
        end
        S_SCANA: begin
          if (scan_cnt == count_a - CNT_W'(1)) begin
            scan_cnt <= '0;
            state    <= S_SCANB;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        S_SCANB: begin
          if (scan_cnt == count_b - CNT_W'(1)) begin
            drain <= 1'b0;
            state <= S_DRAIN;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) state <= S_CHECK;
        end
        S_CHECK: begin
          if (sep) begin
            res_hit <= 1'b0;
            state   <= S_RES;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (axis_cnt == n_p - CNT_W'(1)) begin
            axis_cnt <= '0;
            if (!poly) begin
              poly  <= 1'b1;
              state <= S_EDGE;
            end else begin
              res_hit <= 1'b1;
              state   <= S_RES;
            end
          end else begin
            axis_cnt <= axis_cnt + CNT_W'(1);
            state    <= S_EDGE;
          end
        end
        S_RES: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, res_hit};
            m_axis_tuser  <= res_ovf;
            ovf           <= 1'b0;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCANA || state == S_SCANB) |-> (count_a != '0 && count_b != '0))
    else $error("scan with empty polygon");

  a_ovf_no_hit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[0])
    else $error("collision reported with overflow");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && out_free) |=> (count_a == '0 && count_b == '0 && !ovf))
    else $error("state not cleared after result");

endmodule

FILE: sv/psat_cell.sv
// one vertex cell of a rotating vertex chain
`timescale 1ns / 1ps
module psat_cell #(
  parameter int CW = psat_pkg::COORD_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic          rot,
  input  logic          tail,
  input  logic [CW-1:0] din_x,
  input  logic [CW-1:0] din_y,
  input  logic [CW-1:0] nb_x,
  input  logic [CW-1:0] nb_y,
  input  logic [CW-1:0] wrap_x,
  input  logic [CW-1:0] wrap_y,
  output logic [CW-1:0] x,
  output logic [CW-1:0] y
);

  always_ff @(posedge clk) begin
    if (we) begin
      x <= din_x;
      y <= din_y;
    end else if (rot) begin
      x <= tail ? wrap_x : nb_x;
      y <= tail ? wrap_y : nb_y;
    end
  end

endmodule

FILE: sv/psat_chain.sv
// vertex chain of one polygon with its fill count
`timescale 1ns / 1ps
module psat_chain #(
  parameter int N  = psat_pkg::MAX_VERTS,
  parameter int CW = psat_pkg::COORD_BITS,
  localparam int CNT_W = $clog2(N + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             clr,
  input  logic             rot,
  input  logic [CW-1:0]    in_x,
  input  logic [CW-1:0]    in_y,
  output logic [CNT_W-1:0] count,
  output logic             full,
  output logic [CW-1:0]    h0_x,
  output logic [CW-1:0]    h0_y,
  output logic [CW-1:0]    h1_x,
  output logic [CW-1:0]    h1_y
);

  logic [CW-1:0] cx [N];
  logic [CW-1:0] cy [N];

  assign full = (count == CNT_W'(N));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      count <= '0;
    end else if (load && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [CW-1:0] nbx, nby;
    if (i == N - 1) begin : g_end
      assign nbx = cx[0];
      assign nby = cy[0];
    end else begin : g_mid
      assign nbx = cx[i+1];
      assign nby = cy[i+1];
    end
    psat_cell #(.CW(CW)) u_cell (
      .clk    (clk),
      .we     (load && !full && (count == CNT_W'(i))),
      .rot    (rot),
      .tail   (count == CNT_W'(i + 1)),
      .din_x  (in_x),
      .din_y  (in_y),
      .nb_x   (nbx),
      .nb_y   (nby),
      .wrap_x (cx[0]),
      .wrap_y (cy[0]),
      .x      (cx[i]),
      .y      (cy[i])
    );
  end

  assign h0_x = cx[0];
  assign h0_y = cy[0];
  assign h1_x = (count >= CNT_W'(2)) ? cx[1] : cx[0];
  assign h1_y = (count >= CNT_W'(2)) ? cy[1] : cy[0];

endmodule

FILE: sv/psat_proj.sv
// projection pipeline: dot product and running min and max per polygon
`timescale 1ns / 1ps
module psat_proj #(
  parameter int CW = psat_pkg::COORD_BITS,
  localparam int PW = 2 * CW + 1,
  localparam int DW = 2 * CW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psat_pkg::tag_t       tag,
  input  logic signed [CW:0]   nx,
  input  logic signed [CW:0]   ny,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  output logic signed [DW-1:0] a_lo,
  output logic signed [DW-1:0] a_hi,
  output logic signed [DW-1:0] b_lo,
  output logic signed [DW-1:0] b_hi
);

  psat_pkg::tag_t t1, t2;
  logic signed [PW-1:0] px, py;
  logic signed [DW-1:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
    end else begin
      t1 <= tag;
      t2 <= t1;
    end
  end

  always_ff @(posedge clk) begin
    px <= PW'(nx) * PW'(vx);
    py <= PW'(ny) * PW'(vy);
    d  <= DW'(px) + DW'(py);
  end

  always_ff @(posedge clk) begin
    if (t2.valid) begin
      if (!t2.poly) begin
        if (t2.first || d < a_lo) a_lo <= d;
        if (t2.first || d > a_hi) a_hi <= d;
      end else begin
        if (t2.first || d < b_lo) b_lo <= d;
        if (t2.first || d > b_hi) b_hi <= d;
      end
    end
  end

endmodule
